>>> rtl/deep_bottom_left_fill_placer_macros.svh
// Assertion macros used by the placer top level.
`ifndef DEEP_BOTTOM_LEFT_FILL_PLACER_MACROS_SVH
`define DEEP_BOTTOM_LEFT_FILL_PLACER_MACROS_SVH

// Same-cycle implication, checked on clk and ignored while arst_n is low.
`define DBLF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and ignored while arst_n is low.
`define DBLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dblf_pkg.sv
// Shared constants, types and helper functions of the bottom-left-fill placer.
package dblf_pkg;

	localparam int MAX_EXTENT = 16;
	localparam int COORD_W = $clog2(MAX_EXTENT);
	localparam int ROW_W = MAX_EXTENT;
	localparam int ADDR_W = 2 * COORD_W;
	localparam int DEPTH = MAX_EXTENT * MAX_EXTENT;
	localparam int EXT_W = 5;
	localparam int CNT_W = (EXT_W > $clog2(MAX_EXTENT + 1)) ? EXT_W : $clog2(MAX_EXTENT + 1);
	localparam int VAL_W = 16;
	localparam int SUM_W = 24;
	localparam int POS_W = 4;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEPTH = 2'd2;

	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_ACC,
		ST_EVAL,
		ST_MRD,
		ST_MWR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] cw;
		logic [CNT_W-1:0] ch;
		logic [CNT_W-1:0] cd;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
		logic [ADDR_W-1:0] addr;
		logic [ROW_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic hit;
		logic [COORD_W-1:0] x;
	} fit_t;

	function automatic logic [CNT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = CNT_W'(v);
		if (r == '0)
			r = CNT_W'(1);
		else if (r > CNT_W'(MAX_EXTENT))
			r = CNT_W'(MAX_EXTENT);
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] box_mask(input logic [CNT_W-1:0] bw);
		logic [ROW_W:0] sh;
		sh = (ROW_W+1)'(1) << bw;
		return ROW_W'(sh - (ROW_W+1)'(1));
	endfunction

	function automatic fit_t fit_search(input logic [ROW_W-1:0] acc,
		input logic [CNT_W-1:0] bw, input logic [CNT_W-1:0] cw);
		fit_t r;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] win;
		r.hit = 1'b0;
		r.x = '0;
		mask = box_mask(bw);
		for (int i = MAX_EXTENT - 1; i >= 0; i--) begin
			win = acc >> i;
			if (((CNT_W+1)'(i) + (CNT_W+1)'(bw) <= (CNT_W+1)'(cw)) && ((win & mask) == '0)) begin
				r.hit = 1'b1;
				r.x = COORD_W'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/deep_bottom_left_fill_placer.sv
// Top level of the placer: register port, scanner and occupancy memory.
// A clear item, or a box larger than the container, goes straight to the done state and its result is
// registered once the output slot is free. A placed box reads the rows of each candidate (y,z) pair up
// to the hit, then reads and writes back each of its rows to mark them; one item is worked on at a time.
// This sequence is set by the single read/write port of the occupancy memory.
// After reset every cell is free (per-row valid flags), the total is zero and all extents are 16.
`include "deep_bottom_left_fill_placer_macros.svh"

module deep_bottom_left_fill_placer
	import dblf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 op,
	input  logic [EXT_W-1:0]     box_width,
	input  logic [EXT_W-1:0]     box_height,
	input  logic [EXT_W-1:0]     box_depth,
	input  logic [VAL_W-1:0]     box_value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 placed,
	output logic [POS_W-1:0]     pos_x,
	output logic [POS_W-1:0]     pos_y,
	output logic [POS_W-1:0]     pos_z,
	output logic [SUM_W-1:0]     total_value
);

	logic [EXT_W-1:0] width_q, height_q, depth_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;
	cfg_t cfg;
	mem_req_t mem_req;
	logic [ROW_W-1:0] mem_rd_data;

	assign pready = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= EXT_W'(MAX_EXTENT);
			height_q <= EXT_W'(MAX_EXTENT);
			depth_q <= EXT_W'(MAX_EXTENT);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH: width_q <= pwdata[EXT_W-1:0];
				REG_HEIGHT: height_q <= pwdata[EXT_W-1:0];
				REG_DEPTH: depth_q <= pwdata[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_WIDTH: prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_DEPTH: prdata = PDATA_W'(depth_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.cw = clamp_ext(width_q);
	assign cfg.ch = clamp_ext(height_q);
	assign cfg.cd = clamp_ext(depth_q);

	dblf_scanner u_scanner (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.box_width   (box_width),
		.box_height  (box_height),
		.box_depth   (box_depth),
		.box_value   (box_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.placed      (placed),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.total_value (total_value),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	dblf_occ_mem u_occ_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	`DBLF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "item accepted but placer not busy")
	`DBLF_ASSERT_IMPL(a_unplaced_origin, rsp_valid && !placed, pos_x == '0 && pos_y == '0 && pos_z == '0, "unplaced result has non-zero corner")
	`DBLF_ASSERT_NEXT(a_width_write, cfg_wr && reg_idx == REG_WIDTH, width_q == $past(pwdata[EXT_W-1:0]), "width register write lost")

endmodule

>>> rtl/dblf_occ_mem.sv
// Occupancy row memory with registered reads and per-row valid flags.
module dblf_occ_mem
	import dblf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             req,
	output logic [ROW_W-1:0]     rd_data
);

	logic [ROW_W-1:0] ram_q [DEPTH];
	logic [DEPTH-1:0] row_valid_q;
	logic [ROW_W-1:0] rdata_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			ram_q[req.addr] <= req.wdata;
		if (req.rd_en)
			rdata_q <= ram_q[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr)
				row_valid_q <= '0;
			else if (req.wr_en)
				row_valid_q[req.addr] <= 1'b1;
			if (req.rd_en)
				rd_valid_q <= row_valid_q[req.addr];
		end
	end

	assign rd_data = rd_valid_q ? rdata_q : '0;

endmodule

>>> rtl/dblf_scanner.sv
// Corner scan, region test and marking sequencer with result register.
module dblf_scanner
	import dblf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 op,
	input  logic [EXT_W-1:0]     box_width,
	input  logic [EXT_W-1:0]     box_height,
	input  logic [EXT_W-1:0]     box_depth,
	input  logic [VAL_W-1:0]     box_value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 placed,
	output logic [POS_W-1:0]     pos_x,
	output logic [POS_W-1:0]     pos_y,
	output logic [POS_W-1:0]     pos_z,
	output logic [SUM_W-1:0]     total_value,
	output mem_req_t             mem_req,
	input  logic [ROW_W-1:0]     mem_rd_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] bw_q, bh_q, bd_q;
	logic [VAL_W-1:0] bv_q;
	logic [CNT_W-1:0] z_q, y_q, dz_q, dy_q;
	logic [COORD_W-1:0] hit_x_q;
	logic [ROW_W-1:0] acc_q;
	logic res_placed_q;
	logic [SUM_W-1:0] sum_q;
	logic rsp_valid_q;
	logic placed_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [SUM_W-1:0] total_q;

	logic accept;
	logic fits;
	logic no_rows;
	logic slot_free;
	logic [CNT_W-1:0] bw_in, bh_in, bd_in;
	logic [CNT_W-1:0] zz, yy, dy_inc, dz_inc, y_inc, z_inc;
	logic dy_last, row_last, y_wrap, z_end;
	logic [ADDR_W-1:0] row_addr;
	logic [SUM_W:0] sum_add;
	fit_t fit;

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign bw_in = CNT_W'(box_width);
	assign bh_in = CNT_W'(box_height);
	assign bd_in = CNT_W'(box_depth);
	assign fits = (bw_in <= cfg.cw) && (bh_in <= cfg.ch) && (bd_in <= cfg.cd);
	assign no_rows = (bh_q == '0) || (bd_q == '0);

	assign zz = z_q + dz_q;
	assign yy = y_q + dy_q;
	assign row_addr = {zz[COORD_W-1:0], yy[COORD_W-1:0]};
	assign dy_inc = dy_q + CNT_W'(1);
	assign dz_inc = dz_q + CNT_W'(1);
	assign y_inc = y_q + CNT_W'(1);
	assign z_inc = z_q + CNT_W'(1);
	assign dy_last = (dy_inc == bh_q);
	assign row_last = dy_last && (dz_inc == bd_q);
	assign y_wrap = ({1'b0, y_inc} + {1'b0, bh_q}) > {1'b0, cfg.ch};
	assign z_end = ({1'b0, z_inc} + {1'b0, bd_q}) > {1'b0, cfg.cd};
	assign fit = fit_search(acc_q, bw_q, cfg.cw);
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(bv_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_CLEAR || !fits)
						state_d = ST_DONE;
					else if (bh_in == '0 || bd_in == '0)
						state_d = ST_EVAL;
					else
						state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_ACC;
			ST_ACC: state_d = row_last ? ST_EVAL : ST_RD;
			ST_EVAL: begin
				if (fit.hit)
					state_d = no_rows ? ST_DONE : ST_MRD;
				else if (y_wrap && z_end)
					state_d = ST_DONE;
				else
					state_d = ST_RD;
			end
			ST_MRD: state_d = ST_MWR;
			ST_MWR: state_d = row_last ? ST_DONE : ST_MRD;
			ST_DONE: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req = '0;
		mem_req.addr = row_addr;
		mem_req.wdata = mem_rd_data | ROW_W'(box_mask(bw_q) << hit_x_q);
		unique case (state_q) inside
			ST_IDLE: mem_req.clr = accept && (op == OP_CLEAR);
			ST_RD: mem_req.rd_en = 1'b1;
			ST_MRD: mem_req.rd_en = 1'b1;
			ST_MWR: mem_req.wr_en = 1'b1;
			ST_ACC, ST_EVAL, ST_DONE: mem_req.rd_en = 1'b0;
			default: mem_req.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && slot_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			if (accept && op == OP_CLEAR)
				sum_q <= '0;
			else if (state_q == ST_EVAL && fit.hit)
				sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: begin
				bw_q <= bw_in;
				bh_q <= bh_in;
				bd_q <= bd_in;
				bv_q <= box_value;
				z_q <= '0;
				y_q <= '0;
				dz_q <= '0;
				dy_q <= '0;
				acc_q <= '0;
				hit_x_q <= '0;
				res_placed_q <= 1'b0;
			end
			ST_ACC, ST_MWR: begin
				if (state_q == ST_ACC)
					acc_q <= acc_q | mem_rd_data;
				if (dy_last) begin
					dy_q <= '0;
					dz_q <= dz_inc;
				end else begin
					dy_q <= dy_inc;
				end
			end
			ST_EVAL: begin
				dz_q <= '0;
				dy_q <= '0;
				acc_q <= '0;
				if (fit.hit) begin
					hit_x_q <= fit.x;
					res_placed_q <= 1'b1;
				end else if (y_wrap) begin
					y_q <= '0;
					z_q <= z_inc;
				end else begin
					y_q <= y_inc;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					placed_q <= res_placed_q;
					pos_x_q <= res_placed_q ? POS_W'(hit_x_q) : '0;
					pos_y_q <= res_placed_q ? POS_W'(y_q) : '0;
					pos_z_q <= res_placed_q ? POS_W'(z_q) : '0;
					total_q <= sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign placed = placed_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_z = pos_z_q;
	assign total_value = total_q;

endmodule
